@@ src/cse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_pkg: shared types and constants for the CAN signal extract/scale core
// Holds the transaction structs, the table entry layout and the kind codes.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [1:0] KIND_FLOAT    = 2'd0;
    localparam logic [1:0] KIND_UNSIGNED = 2'd1;
    localparam logic [1:0] KIND_BOOL     = 2'd2;

    localparam logic [3:0]  FRAME_BYTES = 4'd8;
    localparam logic [4:0]  MAX_RESULTS = 5'd16;

    localparam logic [47:0] Q_MAX    = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] Q_MIN    = 48'h8000_0000_0000;
    localparam logic [47:0] U_MAX    = 48'h7FFF_FFFF_0000;
    localparam logic [47:0] BOOL_ONE = 48'h0000_0001_0000;

    typedef struct packed {
        logic               operation;
        logic [3:0]         slot;
        logic               entry_valid;
        logic [28:0]        frame_id;
        logic [2:0]         first_byte;
        logic [2:0]         byte_count;
        logic [1:0]         value_kind;
        logic signed [31:0] scale_factor;
        logic signed [47:0] scale_offset;
        logic [3:0]         frame_length;
        logic [63:0]        payload;
    } item_t;

    typedef struct packed {
        logic [3:0]         signal_slot;
        logic [1:0]         signal_kind;
        logic signed [47:0] signal_value;
        logic               saturated;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [28:0]        frame_id;
        logic [2:0]         first_byte;
        logic [1:0]         count_m1;
        logic [1:0]         kind;
        logic signed [31:0] factor;
        logic signed [47:0] offset;
    } entry_t;

    typedef struct packed {
        logic               hit;
        logic               fin;
        logic [3:0]         slot;
        logic [1:0]         kind;
        logic [31:0]        raw;
        logic signed [31:0] factor;
        logic signed [47:0] offset;
    } scale_in_t;

    typedef struct packed {
        logic               hit;
        logic               fin;
        logic [3:0]         slot;
        logic [1:0]         kind;
        logic signed [47:0] value;
        logic               sat;
    } scale_out_t;

endpackage

@@ src/can_signal_extract_scale_core.sv @@
`timescale 1ns / 1ps
// A decode walks the table RAM one entry per cycle while the result side does
// not stall. Each result is held back until the next fitting one or the end of
// the walk is seen, so that the last one can be marked. No new item, write or
// decode, is accepted while a walk is in progress.
// Reset clears all entry valid bits and the walk control; entry fields stay
// undefined until written.
// ----------------------------------------------------------------------------
// can_signal_extract_scale_core: CAN signal extract and scale engine
// Holds a table of signal entries in RAM, matches each frame against it and
// emits one scaled Q32.16 value per fitting signal, up to MAX_RESULTS, marking the last one.
// ----------------------------------------------------------------------------
module can_signal_extract_scale_core #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  cse_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_stall,
    output cse_pkg::result_t  result
);
    import cse_pkg::*;

    localparam int AW      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int IW      = $clog2(TABLE_ENTRIES + 1);
    localparam int ENTRY_W = $bits(entry_t);

    logic                     busy_reg;
    logic                     issue_reg;
    logic [IW-1:0]            idx_reg;
    logic [28:0]              id_reg;
    logic [3:0]               len_reg;
    logic [63:0]              payload_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic                     s1_v_reg;
    logic                     s1_fin_reg;
    logic [AW-1:0]            s1_idx_reg;
    scale_in_t                s2_reg;
    scale_in_t                s2_next;

    logic [4:0]               count_reg;
    logic                     pend_valid_reg;
    result_t                  pend_reg;
    logic                     out_valid_reg;
    result_t                  out_reg;

    logic                     adv;
    logic                     accept;
    logic                     wr_en;
    logic [6:0]               slot_ext;
    logic [AW-1:0]            wr_addr;
    entry_t                   wr_entry;
    logic [1:0]               wr_cnt_m1;
    logic [1:0]               wr_kind;
    logic [ENTRY_W-1:0]       rd_data;
    entry_t                   rd_entry;
    logic [6:0]               s1_idx_ext;
    logic [3:0]               span;
    logic [63:0]              shifted;
    logic                     at_end;
    scale_out_t               so;
    logic                     out_load;

    assign adv        = !out_valid_reg || !result_stall;
    assign item_stall = busy_reg;
    assign accept     = item_valid && !busy_reg;
    assign at_end     = (idx_reg == IW'(TABLE_ENTRIES));

    assign slot_ext = {3'b000, item.slot};
    assign wr_addr  = slot_ext[AW-1:0];
    assign wr_en    = accept && (item.operation == OP_WRITE)
                      && (slot_ext < 7'(TABLE_ENTRIES));

    always_comb
    begin
        if (item.byte_count == 3'd0)
        begin
            wr_cnt_m1 = 2'd0;
        end
        else if (item.byte_count > 3'd4)
        begin
            wr_cnt_m1 = 2'd3;
        end
        else
        begin
            wr_cnt_m1 = 2'(item.byte_count - 3'd1);
        end
        wr_kind = (item.value_kind > KIND_BOOL) ? KIND_BOOL : item.value_kind;
    end

    assign wr_entry.frame_id   = item.frame_id;
    assign wr_entry.first_byte = item.first_byte;
    assign wr_entry.count_m1   = wr_cnt_m1;
    assign wr_entry.kind       = wr_kind;
    assign wr_entry.factor     = item.scale_factor;
    assign wr_entry.offset     = item.scale_offset;

    cse_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (adv),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign rd_entry   = entry_t'(rd_data);
    assign s1_idx_ext = 7'(s1_idx_reg);
    assign span       = {1'b0, rd_entry.first_byte} + {2'b00, rd_entry.count_m1} + 4'd1;
    assign shifted    = payload_reg >> {rd_entry.first_byte, 3'b000};

    always_comb
    begin
        s2_next.hit    = s1_v_reg && valid_reg[s1_idx_reg]
                         && (rd_entry.frame_id == id_reg) && (span <= len_reg);
        s2_next.fin    = s1_fin_reg;
        s2_next.slot   = s1_idx_ext[3:0];
        s2_next.kind   = rd_entry.kind;
        s2_next.factor = rd_entry.factor;
        s2_next.offset = rd_entry.offset;
        case (rd_entry.count_m1)
            2'd0:    s2_next.raw = {24'h0, shifted[7:0]};
            2'd1:    s2_next.raw = {16'h0, shifted[15:0]};
            2'd2:    s2_next.raw = {8'h0, shifted[23:0]};
            default: s2_next.raw = shifted[31:0];
        endcase
    end

    cse_scale u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .op_in  (s2_reg),
        .op_out (so)
    );

    assign out_load = adv && pend_valid_reg
                      && ((so.hit && (count_reg != MAX_RESULTS)) || so.fin);

    // walk control, entry valid bits and result valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            issue_reg      <= 1'b0;
            idx_reg        <= '0;
            valid_reg      <= '0;
            s1_v_reg       <= 1'b0;
            s1_fin_reg     <= 1'b0;
            s2_reg         <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= item.entry_valid;
            end
            if (accept && (item.operation == OP_DECODE))
            begin
                busy_reg  <= 1'b1;
                issue_reg <= 1'b1;
                idx_reg   <= '0;
                count_reg <= '0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (adv)
            begin
                s2_reg <= s2_next;
                if (issue_reg)
                begin
                    if (at_end)
                    begin
                        s1_v_reg   <= 1'b0;
                        s1_fin_reg <= 1'b1;
                        issue_reg  <= 1'b0;
                    end
                    else
                    begin
                        s1_v_reg   <= 1'b1;
                        s1_fin_reg <= 1'b0;
                        idx_reg    <= idx_reg + 1'b1;
                    end
                end
                else
                begin
                    s1_v_reg   <= 1'b0;
                    s1_fin_reg <= 1'b0;
                end

                if (so.hit && (count_reg != MAX_RESULTS))
                begin
                    pend_valid_reg <= 1'b1;
                    count_reg      <= count_reg + 5'd1;
                end
                if (so.fin)
                begin
                    pend_valid_reg <= 1'b0;
                    busy_reg       <= 1'b0;
                end
            end
        end
    end

    // hold frame context, stage index and result payloads
    always_ff @(posedge clk)
    begin
        if (accept && (item.operation == OP_DECODE))
        begin
            id_reg      <= item.frame_id;
            len_reg     <= (item.frame_length > FRAME_BYTES) ? FRAME_BYTES
                                                             : item.frame_length;
            payload_reg <= item.payload;
        end
        if (adv)
        begin
            if (issue_reg && !at_end)
            begin
                s1_idx_reg <= idx_reg[AW-1:0];
            end
            if (so.hit && (count_reg != MAX_RESULTS))
            begin
                pend_reg.signal_slot  <= so.slot;
                pend_reg.signal_kind  <= so.kind;
                pend_reg.signal_value <= so.value;
                pend_reg.saturated    <= so.sat;
                pend_reg.last         <= 1'b0;
                if (pend_valid_reg)
                begin
                    out_reg <= pend_reg;
                end
            end
            if (so.fin && pend_valid_reg)
            begin
                out_reg <= {pend_reg[$bits(result_t)-1:1], 1'b1};
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ src/cse_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module cse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/cse_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cse_scale: two-stage scaler for one extracted signal
// Multiplies raw by the Q16.16 factor, adds the Q32.16 offset, then
// saturates or truncates by signal kind; a bool gives one when raw is nonzero.
// ----------------------------------------------------------------------------
module cse_scale (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  cse_pkg::scale_in_t     op_in,
    output cse_pkg::scale_out_t    op_out
);
    import cse_pkg::*;

    logic               a_hit_reg;
    logic               a_fin_reg;
    logic [3:0]         a_slot_reg;
    logic [1:0]         a_kind_reg;
    logic               a_nz_reg;
    logic signed [64:0] a_prod_reg;
    logic signed [47:0] a_off_reg;

    logic               b_hit_reg;
    logic               b_fin_reg;
    logic [3:0]         b_slot_reg;
    logic [1:0]         b_kind_reg;
    logic               b_nz_reg;
    logic signed [65:0] b_sum_reg;

    logic signed [64:0] prod;
    logic signed [65:0] sum;
    logic signed [47:0] value;
    logic               sat;

    assign prod = $signed({1'b0, op_in.raw}) * op_in.factor;
    assign sum  = {a_prod_reg[64], a_prod_reg} + {{18{a_off_reg[47]}}, a_off_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_hit_reg <= 1'b0;
            a_fin_reg <= 1'b0;
            b_hit_reg <= 1'b0;
            b_fin_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_hit_reg <= op_in.hit;
            a_fin_reg <= op_in.fin;
            b_hit_reg <= a_hit_reg;
            b_fin_reg <= a_fin_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_slot_reg <= op_in.slot;
            a_kind_reg <= op_in.kind;
            a_nz_reg   <= |op_in.raw;
            a_prod_reg <= prod;
            a_off_reg  <= op_in.offset;
            b_slot_reg <= a_slot_reg;
            b_kind_reg <= a_kind_reg;
            b_nz_reg   <= a_nz_reg;
            b_sum_reg  <= sum;
        end
    end

    always_comb
    begin
        value = '0;
        sat   = 1'b0;
        case (b_kind_reg)
            KIND_FLOAT:
            begin
                if ((&b_sum_reg[65:47]) || !(|b_sum_reg[65:47]))
                begin
                    value = b_sum_reg[47:0];
                end
                else
                begin
                    sat   = 1'b1;
                    value = b_sum_reg[65] ? Q_MIN : Q_MAX;
                end
            end
            KIND_UNSIGNED:
            begin
                if (b_sum_reg[65])
                begin
                    value = '0;
                    sat   = !((&b_sum_reg[65:16]) && (|b_sum_reg[15:0]));
                end
                else if (|b_sum_reg[64:47])
                begin
                    value = U_MAX;
                    sat   = 1'b1;
                end
                else
                begin
                    value = {1'b0, b_sum_reg[46:16], 16'h0000};
                end
            end
            default:
            begin
                value = b_nz_reg ? BOOL_ONE : '0;
            end
        endcase
    end

    assign op_out.hit   = b_hit_reg;
    assign op_out.fin   = b_fin_reg;
    assign op_out.slot  = b_slot_reg;
    assign op_out.kind  = b_kind_reg;
    assign op_out.value = value;
    assign op_out.sat   = sat;

endmodule
